// ===== src/utf8_case_converter_assert.svh =====
// ----------------------------------------------------------------------------
// utf8_case_converter assertion macros
// Shared concurrent assertion forms for the UTF-8 case converter checkers.
// ----------------------------------------------------------------------------
`ifndef UTF8_CASE_CONVERTER_ASSERT_SVH
`define UTF8_CASE_CONVERTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define U8CC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define U8CC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/u8cc_pkg.sv =====
// ----------------------------------------------------------------------------
// u8cc_pkg
// Types, constants and case-mapping / encoding functions of the UTF-8 case
// converter.
// ----------------------------------------------------------------------------
package u8cc_pkg;

    // Case mode register codes
    localparam logic [1:0] CASE_PASS  = 2'd0;
    localparam logic [1:0] CASE_LOWER = 2'd1;
    localparam logic [1:0] CASE_UPPER = 2'd2;

    // Output byte queue sizing
    localparam int MAX_BYTES  = 3;
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam logic [FIFO_AW:0] READY_LIMIT = (FIFO_AW + 1)'(FIFO_DEPTH - 2 * MAX_BYTES);

    // One re-encoded character
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [1:0]                len;
    } t_utf8_enc;

    // One queued output byte
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       letter;
    } t_out_entry;

    function automatic logic [15:0] map_lower(input logic [15:0] c);
        logic [15:0] m;
        m = c;
        if (c inside {[16'h0041:16'h005A]}) begin
            m = c + 16'h0020;
        end else if (c inside {[16'h00C0:16'h00DE]} && c != 16'h00D7) begin
            m = c + 16'h0020;
        end else if (c == 16'h0152) begin
            m = 16'h0153;
        end else if (c == 16'h0160) begin
            m = 16'h0161;
        end else if (c inside {[16'h0410:16'h042F]}) begin
            m = c + 16'h0020;
        end else if (c == 16'h0401) begin
            m = 16'h0451;
        end
        return m;
    endfunction

    function automatic logic [15:0] map_upper(input logic [15:0] c);
        logic [15:0] m;
        m = c;
        if (c inside {[16'h0061:16'h007A]}) begin
            m = c - 16'h0020;
        end else if (c inside {[16'h00E0:16'h00FE]} && c != 16'h00F7) begin
            m = c - 16'h0020;
        end else if (c == 16'h0153) begin
            m = 16'h0152;
        end else if (c == 16'h0161) begin
            m = 16'h0160;
        end else if (c inside {[16'h0430:16'h044F]}) begin
            m = c - 16'h0020;
        end else if (c == 16'h0451) begin
            m = 16'h0401;
        end
        return m;
    endfunction

    function automatic logic letter_test(input logic [15:0] c);
        return (c inside {[16'h0061:16'h007A]}) ||
               (c inside {[16'h0041:16'h005A]}) ||
               (c == 16'h0027) ||
               ((c inside {[16'h00C0:16'h00FF]}) && c != 16'h00D7 && c != 16'h00F7) ||
               (c == 16'h0152) || (c == 16'h0153) ||
               (c == 16'h0160) || (c == 16'h0161) ||
               (c inside {[16'h0410:16'h044F]}) ||
               (c == 16'h0401) || (c == 16'h0451);
    endfunction

    function automatic t_utf8_enc utf8_encode(input logic [15:0] m);
        t_utf8_enc e;
        e = '0;
        if (m < 16'h0080) begin
            e.bytes[0] = m[7:0];
            e.len      = 2'd1;
        end else if (m < 16'h0800) begin
            e.bytes[0] = {3'b110, m[10:6]};
            e.bytes[1] = {2'b10, m[5:0]};
            e.len      = 2'd2;
        end else begin
            e.bytes[0] = {4'b1110, m[15:12]};
            e.bytes[1] = {2'b10, m[11:6]};
            e.bytes[2] = {2'b10, m[5:0]};
            e.len      = 2'd3;
        end
        return e;
    endfunction

endpackage

// ===== src/utf8_case_converter.sv =====
// A character's first output byte is offered once its last input byte has passed through
// the input register and then the output queue; remaining bytes follow one per output transaction.
// Throughput: one input byte and one output byte per cycle, the latter while i_out_ready is
// high; input ready drops only in reset or while the 16-entry output byte queue holds more
// than 10 bytes. Reset (synchronous, active low): decoder state cleared, case mode set
// to pass through, output queue emptied, input ready held low.
// ----------------------------------------------------------------------------
// utf8_case_converter
// Decodes a UTF-8 byte stream, optionally maps each character to lower or
// upper case and re-encodes it, one output byte per transaction.
// ----------------------------------------------------------------------------
module utf8_case_converter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_stream_start,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_char_end,
    output logic       o_is_letter
);
    import u8cc_pkg::*;

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_start;
    logic [1:0]          r_mode;
    logic [1:0]          r_pend;
    logic [1:0]          n_pend;
    logic [15:0]         r_acc;
    logic [15:0]         n_acc;
    logic [1:0]          pend_base;
    logic                char_done;
    logic [15:0]         mapped;
    logic                letter;
    t_utf8_enc           enc;
    t_out_entry          r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wr_ptr;
    logic [FIFO_AW-1:0]  r_rd_ptr;
    logic [FIFO_AW:0]    r_count;
    logic [FIFO_AW:0]    n_count;
    logic [1:0]          push_len;
    logic                pop;
    logic                in_accept;

    assign in_accept = i_in_valid & o_in_ready;
    assign o_in_ready = i_rst_n & (r_count <= READY_LIMIT);

    // Capture accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept;
        end
        if (in_accept) begin
            r_in_byte  <= i_in_byte;
            r_in_start <= i_stream_start;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= CASE_PASS;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    // Decode: advance the pending count and accumulate the code point
    always_comb begin
        pend_base = r_in_start ? 2'd0 : r_pend;
        n_pend    = r_pend;
        n_acc     = r_acc;
        char_done = 1'b0;
        if (r_in_valid) begin
            if (pend_base == 2'd0) begin
                if (!r_in_byte[7]) begin
                    n_acc     = {8'h00, r_in_byte};
                    n_pend    = 2'd0;
                    char_done = 1'b1;
                end else if (!r_in_byte[5]) begin
                    n_acc  = {11'h000, r_in_byte[4:0]};
                    n_pend = 2'd1;
                end else begin
                    n_acc  = {12'h000, r_in_byte[3:0]};
                    n_pend = 2'd2;
                end
            end else begin
                n_acc     = {r_acc[9:0], r_in_byte[5:0]};
                n_pend    = pend_base - 2'd1;
                char_done = (pend_base == 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
            r_acc  <= 16'h0000;
        end else begin
            r_pend <= n_pend;
            r_acc  <= n_acc;
        end
    end

    // Case map, letter flag and re-encode
    always_comb begin
        case (r_mode)
            CASE_LOWER: mapped = map_lower(n_acc);
            CASE_UPPER: mapped = map_upper(n_acc);
            default:    mapped = n_acc;
        endcase
        letter = letter_test(n_acc);
        enc    = utf8_encode(mapped);
    end

    // Output byte queue: push a whole character, pop one byte per transaction
    assign push_len = char_done ? enc.len : 2'd0;
    assign pop      = o_out_valid & i_out_ready;
    assign n_count  = r_count + {{(FIFO_AW - 1){1'b0}}, push_len} - {{FIFO_AW{1'b0}}, pop};

    always_ff @(posedge i_clk) begin
        if (char_done) begin
            for (int k = 0; k < MAX_BYTES; k++) begin
                if (2'(k) < enc.len) begin
                    r_fifo[r_wr_ptr + FIFO_AW'(k)] <= '{
                        data:   enc.bytes[k],
                        last:   (2'(k) == enc.len - 2'd1),
                        letter: letter
                    };
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(push_len);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= n_count;
        end
    end

    // Drive output from the queue head
    assign o_out_valid = (r_count != '0);
    assign o_out_byte  = r_fifo[r_rd_ptr].data;
    assign o_char_end  = r_fifo[r_rd_ptr].last;
    assign o_is_letter = r_fifo[r_rd_ptr].letter;

endmodule

// ===== src/u8cc_checker.sv =====
// ----------------------------------------------------------------------------
// u8cc_checker
// Port-level checks of the UTF-8 case converter output stream.
// ----------------------------------------------------------------------------
`include "utf8_case_converter_assert.svh"

module u8cc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_we,
    input logic [1:0] i_cfg_data,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [7:0] i_in_byte,
    input logic       i_stream_start,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_char_end,
    input logic       o_is_letter
);

    // Hold a stalled output transaction
    `U8CC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_byte) && $stable(o_char_end), "output changed while stalled")

    // A byte below 0x80 is always a whole character; a lead byte never ends one
    `U8CC_ASSERT_SAME(a_byte_class, i_clk, i_rst_n, o_out_valid, (o_out_byte[7] || o_char_end) && (o_out_byte[7:6] != 2'b11 || !o_char_end), "bad end mark for byte class")

    // Rest of a character is queued with it: continuation byte follows at once
    `U8CC_ASSERT_NEXT(a_char_cont, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_char_end, o_out_valid && o_out_byte[7:6] == 2'b10 && o_is_letter == $past(o_is_letter), "character bytes not contiguous")

    // Drop all output after reset
    `U8CC_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !o_out_valid, "output valid after reset")

endmodule

bind utf8_case_converter u8cc_checker u_checker (.*);
